// ===== rtl/core/oel_pkg.sv =====
// shared types, constants and sequencer states for the one euro adaptive low-pass unit
`default_nettype none
package oel_pkg;

    // fraction bits of sample and speed values
    localparam int FRAC_BITS   = 16;
    // fixed q0.16 scaling used by the smoothing and output steps
    localparam int Q16_BITS    = 16;
    localparam int EST_W       = 48;
    localparam int MUL_A_W     = 48;
    localparam int MUL_B_W     = 24;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int W_W         = 35;
    localparam int DEN_W       = 36;

    localparam logic [EST_W-1:0]   EST_MAX    = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic [EST_W-1:0]   EST_MIN    = {1'b1, {(EST_W-1){1'b0}}};
    localparam logic [23:0]        TWO_PI_Q16 = 24'd411775;
    localparam logic [16:0]        ONE_Q16    = 17'd65536;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_RATE  = 2'd2;
    localparam logic [1:0] REG_SMOOTHING    = 2'd3;

    // request opcodes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_ALIGN  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] sample_value;
    } oel_in_t;

    typedef struct packed {
        logic signed [31:0] filtered_value;
        logic               active;
    } oel_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPEED,
        S_SAT,
        S_DELTA,
        S_EST,
        S_UPD,
        S_MAG,
        S_HI,
        S_LO,
        S_TERM,
        S_W,
        S_DEN,
        S_DIVI,
        S_DIV,
        S_OUT,
        S_FIN
    } oel_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/one_euro_adaptive_lowpass_unit.sv =====
// one euro adaptive low-pass filter: sequencer around one shared multiplier and divider step
//
// Input channel in_valid/in_ready/in_data carries one request: opcode and a signed Q16.16
// sample. An align request loads the output with the sample, clears the speed estimate
// and sets active. A filter request before the first align returns the held output.
// Output channel out_valid/out_ready/out_data returns exactly one result per request.
// An active filter request runs a chain of multiplies through the one 48x24 multiplier
// and, when den is non-zero, the 17 restoring divide steps that form alpha.
// A new request is taken only when the sequencer is idle. in_ready rises again
// while a result still waits in the output register; a finished result waits until
// the output register is empty or out_ready is high before it is written, so a
// stalled receiver holds the sequencer in its last step.
// The configuration port cfg_we/cfg_index/cfg_data writes a register and
// clears output, speed estimate and active. Reset (rst_n low) loads the default
// registers, clears the state and empties the output register.
`default_nettype none
module one_euro_adaptive_lowpass_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire oel_pkg::oel_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output oel_pkg::oel_out_t     out_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [23:0]      cfg_data
);
    import oel_pkg::*;

    oel_state_t state_reg, state_next;

    logic [23:0]          min_cut_reg;
    logic [23:0]          gain_reg;
    logic [15:0]          rate_reg;
    logic [16:0]          smooth_reg;

    logic [31:0]          out_val_reg, out_val_next;
    logic [EST_W-1:0]     est_reg, est_next;
    logic                 aligned_reg, aligned_next;

    logic [32:0]          diff_reg, diff_next;
    logic [EST_W-1:0]     spd_reg, spd_next;
    logic [EST_W-1:0]     dmag_reg, dmag_next;
    logic                 dneg_reg, dneg_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    term_reg, term_next;
    logic [31:0]          cut_reg, cut_next;
    logic [W_W-1:0]       w_reg, w_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [16:0]          nlow_reg, nlow_next;
    logic [16:0]          quot_reg, quot_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                 out_valid_reg, out_valid_next;
    oel_out_t             out_data_reg, out_data_next;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    prod_next;

    // scratch values of the combinational step
    logic [32:0]          diff_mag;
    logic [48:0]          d49;
    logic [EST_W-1:0]     d48;
    logic [63:0]          rsum64;
    logic [48:0]          r49;
    logic [48:0]          e49;
    logic [PROD_W-1:0]    tsum;
    logic [32:0]          c33;
    logic [51:0]          num;
    logic [DEN_W:0]       rr;
    logic [16:0]          alpha;
    logic [49:0]          rsum50;
    logic [33:0]          r34;
    logic [33:0]          o34;
    logic [16:0]          smooth_eff;
    logic                 in_fire;
    logic                 cfg_hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_hit   = cfg_we;
    assign smooth_eff = (smooth_reg > ONE_Q16) ? ONE_Q16 : smooth_reg;
    assign diff_mag  = diff_reg[32] ? (33'd0 - diff_reg) : diff_reg;
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cut_reg   <= 24'd65536;
            gain_reg      <= 24'd0;
            rate_reg      <= 16'd1000;
            smooth_reg    <= 17'd409;
            out_val_reg   <= 32'd0;
            est_reg       <= '0;
            aligned_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_hit)
            begin
                case (cfg_index)
                    REG_MIN_CUTOFF:  min_cut_reg <= cfg_data;
                    REG_SPEED_GAIN:  gain_reg    <= cfg_data;
                    REG_SAMPLE_RATE: rate_reg    <= cfg_data[15:0];
                    REG_SMOOTHING:   smooth_reg  <= cfg_data[16:0];
                    default:         rate_reg    <= rate_reg;
                endcase
                out_val_reg <= 32'd0;
                est_reg     <= '0;
                aligned_reg <= 1'b0;
            end
            else
            begin
                out_val_reg <= out_val_next;
                est_reg     <= est_next;
                aligned_reg <= aligned_next;
            end
        end
    end

    // datapath working registers
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        spd_reg      <= spd_next;
        dmag_reg     <= dmag_next;
        dneg_reg     <= dneg_next;
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        cut_reg      <= cut_next;
        w_reg        <= w_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        nlow_reg     <= nlow_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    // sequencer: next state, operand selection and step arithmetic
    always_comb
    begin
        state_next     = state_reg;
        out_val_next   = out_val_reg;
        est_next       = est_reg;
        aligned_next   = aligned_reg;
        diff_next      = diff_reg;
        spd_next       = spd_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        term_next      = term_reg;
        cut_next       = cut_reg;
        w_next         = w_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        nlow_next      = nlow_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = '0;
        mul_b          = '0;
        d49            = '0;
        d48            = '0;
        rsum64         = '0;
        r49            = '0;
        e49            = '0;
        tsum           = '0;
        c33            = '0;
        num            = '0;
        rr             = '0;
        alpha          = '0;
        rsum50         = '0;
        r34            = '0;
        o34            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.opcode == OP_ALIGN)
                    begin
                        out_val_next = in_data.sample_value;
                        est_next     = '0;
                        aligned_next = 1'b1;
                        state_next   = S_FIN;
                    end
                    else if (!aligned_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        diff_next  = {in_data.sample_value[31], in_data.sample_value}
                                   - {out_val_reg[31], out_val_reg};
                        state_next = S_SPEED;
                    end
                    // mark the request as one that needs no output update
                    dneg_next = 1'b0;
                    quot_next = '0;
                end
            end

            // |diff| * rate
            S_SPEED:
            begin
                mul_a      = MUL_A_W'(diff_mag);
                mul_b      = MUL_B_W'(rate_reg);
                quot_next  = 17'd1;
                state_next = S_SAT;
            end

            // signed speed, saturated to the estimate width
            S_SAT:
            begin
                if (diff_reg[32])
                begin
                    spd_next = (prod_reg[47:0] > EST_MIN) ? EST_MIN
                                                          : (48'd0 - prod_reg[47:0]);
                end
                else
                begin
                    spd_next = prod_reg[47] ? EST_MAX : prod_reg[47:0];
                end
                state_next = S_DELTA;
            end

            // d = speed - estimate, saturated, split into sign and magnitude
            S_DELTA:
            begin
                d49 = {spd_reg[47], spd_reg} - {est_reg[47], est_reg};
                if (d49[48] != d49[47])
                begin
                    d48 = d49[48] ? EST_MIN : EST_MAX;
                end
                else
                begin
                    d48 = d49[47:0];
                end
                dneg_next  = d48[47];
                dmag_next  = d48[47] ? (48'd0 - d48) : d48;
                state_next = S_EST;
            end

            // |d| * smoothing
            S_EST:
            begin
                mul_a      = dmag_reg;
                mul_b      = MUL_B_W'(smooth_eff);
                state_next = S_UPD;
            end

            // estimate += round(d * s), saturated
            S_UPD:
            begin
                rsum64 = prod_reg[63:0] + 64'd32768;
                r49    = {1'b0, rsum64[63:Q16_BITS]};
                e49    = {est_reg[47], est_reg} + (dneg_reg ? (49'd0 - r49) : r49);
                if (e49[48] != e49[47])
                begin
                    est_next = e49[48] ? EST_MIN : EST_MAX;
                end
                else
                begin
                    est_next = e49[47:0];
                end
                state_next = S_MAG;
            end

            // magnitude of the new estimate
            S_MAG:
            begin
                dmag_next  = est_reg[47] ? (48'd0 - est_reg) : est_reg;
                state_next = S_HI;
            end

            // gain * integer part of |estimate|
            S_HI:
            begin
                mul_a      = MUL_A_W'(dmag_reg[EST_W-1:FRAC_BITS]);
                mul_b      = gain_reg;
                state_next = S_LO;
            end

            // gain * fraction part of |estimate|
            S_LO:
            begin
                term_next  = prod_reg;
                mul_a      = MUL_A_W'(dmag_reg[FRAC_BITS-1:0]);
                mul_b      = gain_reg;
                state_next = S_TERM;
            end

            // cutoff = min cutoff + term, saturated to 32 bits
            S_TERM:
            begin
                tsum = term_reg + (prod_reg >> FRAC_BITS);
                c33  = {9'd0, min_cut_reg} + {1'b0, tsum[31:0]};
                if ((|tsum[PROD_W-1:32]) || c33[32])
                begin
                    cut_next = 32'hFFFF_FFFF;
                end
                else
                begin
                    cut_next = c33[31:0];
                end
                state_next = S_W;
            end

            // w = cutoff * 2 pi
            S_W:
            begin
                mul_a      = MUL_A_W'(cut_reg);
                mul_b      = TWO_PI_Q16;
                state_next = S_DEN;
            end

            // den = w + rate in q16
            S_DEN:
            begin
                w_next     = prod_reg[W_W+15:16];
                den_next   = {1'b0, prod_reg[W_W+15:16]} + {4'd0, rate_reg, 16'd0};
                state_next = S_DIVI;
            end

            // load the divider with the rounded numerator
            S_DIVI:
            begin
                num        = {1'b0, w_reg, 16'd0} + {17'd0, den_reg[DEN_W-1:1]};
                rem_next   = {1'b0, num[51:17]};
                nlow_next  = num[16:0];
                quot_next  = '0;
                cnt_next   = '0;
                state_next = (den_reg == '0) ? S_OUT : S_DIV;
            end

            // one restoring divide step a cycle
            S_DIV:
            begin
                rr        = {rem_reg, nlow_reg[16]};
                nlow_next = {nlow_reg[15:0], 1'b0};
                if (rr >= {1'b0, den_reg})
                begin
                    rem_next  = DEN_W'(rr - {1'b0, den_reg});
                    quot_next = {quot_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next  = rr[DEN_W-1:0];
                    quot_next = {quot_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end

            // |diff| * alpha
            S_OUT:
            begin
                alpha      = (quot_reg > ONE_Q16) ? ONE_Q16 : quot_reg;
                mul_a      = MUL_A_W'(diff_mag);
                mul_b      = MUL_B_W'(alpha);
                dneg_next  = 1'b1;
                state_next = S_FIN;
            end

            // output update on a filter request, then write the result
            S_FIN:
            begin
                if (dneg_reg)
                begin
                    rsum50 = prod_reg[49:0] + 50'd32768;
                    r34    = {1'b0, rsum50[48:16]};
                    o34    = {{2{out_val_reg[31]}}, out_val_reg}
                           + (diff_reg[32] ? (34'd0 - r34) : r34);
                    if ((o34[33:31] != 3'b000) && (o34[33:31] != 3'b111))
                    begin
                        out_val_next = o34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        out_val_next = o34[31:0];
                    end
                    dneg_next = 1'b0;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_data_next.filtered_value = out_val_reg;
                    out_data_next.active         = aligned_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // align request loads the output and activates the filter
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.opcode == OP_ALIGN && !cfg_we)
            |=> (aligned_reg && out_val_reg == $past(in_data.sample_value) && est_reg == '0))
        else $error("align request did not load the filter state");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // an inactive result always carries a cleared output
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.active) |-> (out_data.filtered_value == 32'sd0))
        else $error("inactive result with non-zero output");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the one euro adaptive low-pass unit
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: bit-exact prediction of the filter and a queue of expected results
class oel_scoreboard;
    longint unsigned min_cut;
    longint unsigned gain;
    longint unsigned rate;
    longint unsigned smooth;
    longint          out_val;
    longint          est;
    bit              aligned;
    oel_pkg::oel_out_t expected_q[$];
    int unsigned     errors;
    int unsigned     n_checked;
    int unsigned     n_aligns;
    int unsigned     n_filters;

    function new();
        min_cut   = 65536;
        gain      = 0;
        rate      = 1000;
        smooth    = 409;
        errors    = 0;
        n_checked = 0;
        n_aligns  = 0;
        n_filters = 0;
        clear_state();
    endfunction

    function void clear_state();
        out_val = 0;
        est     = 0;
        aligned = 0;
    endfunction

    function longint clamp48(longint v);
        longint hi;
        hi = 64'sh7FFF_FFFF_FFFF;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // round(a * m / 2^16), ties away from zero
    function longint mul_q16(longint a, longint unsigned m);
        bit              neg;
        longint unsigned mag;
        longint unsigned r;
        neg = a < 0;
        mag = neg ? longint'(-a) : longint'(a);
        r   = (mag * m + 64'd32768) >> 16;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
        case (idx)
            oel_pkg::REG_MIN_CUTOFF:  min_cut = 64'(val);
            oel_pkg::REG_SPEED_GAIN:  gain    = 64'(val);
            oel_pkg::REG_SAMPLE_RATE: rate    = 64'(val[15:0]);
            oel_pkg::REG_SMOOTHING:   smooth  = 64'(val[16:0]);
            default: ;
        endcase
        clear_state();
    endfunction

    // note an accepted request and queue the result it must produce
    function void note_request(oel_pkg::oel_in_t req);
        longint          sample, diff, spd, d;
        longint unsigned s, mag, term, cutoff, w, den, alpha;
        oel_pkg::oel_out_t res;
        sample = longint'(req.sample_value);
        if (req.opcode == oel_pkg::OP_ALIGN) begin
            out_val = sample;
            est     = 0;
            aligned = 1;
            n_aligns++;
        end
        else if (aligned) begin
            n_filters++;
            diff = sample - out_val;
            spd  = clamp48(diff * longint'(rate));
            d    = clamp48(spd - est);
            s    = (smooth > 65536) ? 65536 : smooth;
            est  = clamp48(est + mul_q16(d, s));
            mag  = (est < 0) ? longint'(-est) : longint'(est);
            term = gain * (mag >> 16) + ((gain * (mag & 64'hFFFF)) >> 16);
            cutoff = min_cut + term;
            if (term > 64'hFFFF_FFFF || cutoff > 64'hFFFF_FFFF)
                cutoff = 64'hFFFF_FFFF;
            w   = (cutoff * 64'd411775) >> 16;
            den = w + (rate << 16);
            alpha = (den == 0) ? 0 : (w * 64'd65536 + (den >> 1)) / den;
            if (alpha > 65536)
                alpha = 65536;
            out_val = clamp32(out_val + mul_q16(diff, alpha));
        end
        res.filtered_value = out_val[31:0];
        res.active         = aligned;
        expected_q.push_back(res);
    endfunction

    // compare one delivered result with the oldest expectation
    function void check_result(oel_pkg::oel_out_t got);
        oel_pkg::oel_out_t exp_r;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result value=%0d active=%0b",
                     $realtime, got.filtered_value, got.active);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        n_checked++;
        if (got.filtered_value !== exp_r.filtered_value) begin
            $display("%0t: filtered_value mismatch expected=%0d actual=%0d",
                     $realtime, exp_r.filtered_value, got.filtered_value);
            errors++;
        end
        if (got.active !== exp_r.active) begin
            $display("%0t: active mismatch expected=%0b actual=%0b",
                     $realtime, exp_r.active, got.active);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_top;
    import oel_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    oel_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    oel_out_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    oel_scoreboard sb;
    bit          quiet;
    bit          hold_req;
    int unsigned cycles;
    longint      last_sample;

    one_euro_adaptive_lowpass_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 0;
    always #2 clk = ~clk;

    // monitor both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                repeat (300) @(negedge clk);
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready = 0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready = 1;
        end
    end

    // offer one request, called at a falling edge, returns at a falling edge
    task automatic send_request(logic op, logic [31:0] val);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid             = 1;
        in_data.opcode       = op;
        in_data.sample_value = val;
        last_sample          = longint'($signed(val));
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // register write once every result is back
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        in_valid = 0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_all(logic [23:0] mc, logic [23:0] g, logic [23:0] r, logic [23:0] s);
        write_reg(REG_MIN_CUTOFF, mc);
        write_reg(REG_SPEED_GAIN, g);
        write_reg(REG_SAMPLE_RATE, r);
        write_reg(REG_SMOOTHING, s);
    endtask

    // one stretch of mostly well-formed traffic: align, then a walk of samples
    task automatic run_phase(int n);
        logic [31:0] v;
        send_request(OP_ALIGN, $urandom);
        for (int i = 1; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       send_request(OP_ALIGN, $urandom);
                1, 2:    send_request(OP_FILTER, $urandom);
                3:       send_request(OP_FILTER, $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                   : 32'h8000_0000);
                default:
                begin
                    v = last_sample[31:0] + $signed($urandom_range(0, 1 << 20))
                        - (1 << 19);
                    send_request(OP_FILTER, v);
                end
            endcase
        end
    endtask

    initial
    begin
        sb          = new();
        quiet       = 0;
        hold_req    = 0;
        cycles      = 0;
        last_sample = 0;
        rst_n       = 0;
        in_valid    = 0;
        in_data     = '0;
        cfg_we      = 0;
        cfg_index   = REG_MIN_CUTOFF;
        cfg_data    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: requests before align, extremes, align at extremes
        send_request(OP_FILTER, 32'h7FFF_FFFF);
        send_request(OP_FILTER, 32'h8000_0000);
        send_request(OP_ALIGN, 32'h0000_0000);
        send_request(OP_FILTER, 32'h7FFF_FFFF);
        send_request(OP_FILTER, 32'h8000_0000);
        send_request(OP_FILTER, 32'h0001_0000);
        send_request(OP_ALIGN, 32'h8000_0000);
        send_request(OP_FILTER, 32'h7FFF_FFFF);
        send_request(OP_ALIGN, 32'h7FFF_FFFF);
        send_request(OP_FILTER, 32'h8000_0000);
        send_request(OP_FILTER, 32'hFFFF_FFFF);
        send_request(OP_FILTER, 32'h0000_0000);

        // extreme settings: all maximum, smoothing above one
        set_all(24'hFF_FFFF, 24'hFF_FFFF, 24'h00_FFFF, 24'h01_FFFF);
        send_request(OP_ALIGN, 32'h8000_0000);
        send_request(OP_FILTER, 32'h7FFF_FFFF);
        send_request(OP_FILTER, 32'h8000_0000);
        // smoothing zero, rate zero and cutoff zero: output holds
        set_all(24'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_ALIGN, 32'h1234_5678);
        send_request(OP_FILTER, 32'h8000_0000);
        // rate zero otherwise: output jumps to the sample
        write_reg(REG_MIN_CUTOFF, 24'd65536);
        send_request(OP_ALIGN, 32'h0);
        send_request(OP_FILTER, 32'h7FFF_FFFF);
        // config write clears active
        write_reg(REG_SMOOTHING, 24'd65536);
        send_request(OP_FILTER, 32'h5555_AAAA);

        // random phases over several settings
        set_all(24'd1, 24'd0, 24'd1, 24'd1);
        run_phase(40);
        set_all(24'd65536, 24'd65536, 24'd1000, 24'd409);
        hold_req = 1;
        run_phase(60);
        set_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFFFF, 24'd65536);
        run_phase(40);
        for (int p = 0; p < 6; p++)
        begin
            set_all(24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom_range(0, 24'hFF_FFFF)),
                    24'($urandom_range(1, 16'hFFFF)), 24'($urandom_range(1, 65536)));
            run_phase(45);
        end
        set_all(24'd163840, 24'd7000, 24'd500, 24'd2000);
        quiet = 1;
        run_phase(60);
        in_valid = 0;

        while (sb.pending() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("checked %0d results: %0d aligns, %0d active filter steps",
                 sb.n_checked, sb.n_aligns, sb.n_filters);
        $display("register extremes, rate and smoothing corner cases, long output stall");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/oel_pkg.sv
rtl/core/one_euro_adaptive_lowpass_unit.sv
tb/tb_top.sv
